[sv/radix_partition_count_scatter_unit_macros.svh]
// assertion macros shared by the radix partition unit
// needs a clock named clock and a reset named reset in the including scope
`ifndef RADIX_PARTITION_COUNT_SCATTER_UNIT_MACROS_SVH
`define RADIX_PARTITION_COUNT_SCATTER_UNIT_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define RPCS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rpcs same-cycle check failed");

// next-cycle implication, skipped while reset is high
`define RPCS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rpcs next-cycle check failed");

`endif

[sv/rpcs_pkg.sv]
// types and constants of the radix partition count/scatter unit
// no dependencies; imported by the controller, the datapath and the top level
package rpcs_pkg;

   // request operation codes
   localparam logic [1:0] OP_CLEAR   = 2'd0;
   localparam logic [1:0] OP_COUNT   = 2'd1;
   localparam logic [1:0] OP_SCATTER = 2'd2;

   // configuration register indexes
   localparam logic REG_RADIX_BIT_COUNT = 1'b0;
   localparam logic REG_BYPASS          = 1'b1;

   localparam logic [3:0] RADIX_BIT_COUNT_RESET = 4'd10;

   localparam int BUCKET_ID_W = 10;
   localparam int SLOT_W      = 16;
   localparam int ROW_W       = 16;
   localparam int SIZE_W      = 17;
   localparam int PADDR_W     = 3;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] key_value;
   } req_type;

   typedef struct packed {
      logic [BUCKET_ID_W-1:0] bucket_id;
      logic [SLOT_W-1:0]      slot_in_bucket;
      logic [ROW_W-1:0]       row_number;
      logic [SIZE_W-1:0]      bucket_size;
      logic                   overflow;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;     // latch bucket of the incoming request, start table read
      logic commit;      // write back the updated entry
      logic scatter;     // committed request is a scatter
      logic clear_step;  // zero one table entry of the sweep
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sweep_last;  // sweep is at the last entry
      logic out_free;    // result register can take a new result
   } status_type;

endpackage

[sv/rpcs_ctrl.sv]
// controller state machine of the radix partition unit
// depends on rpcs_pkg; drives rpcs_datapath through cmd_type
module rpcs_ctrl
   import rpcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_op,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       scatter_ff, scatter_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      scatter_in = scatter_ff;
      cmd        = '0;
      cmd.scatter = scatter_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_op)
                  OP_CLEAR: begin
                     state_in = ST_SWEEP;
                  end
                  OP_COUNT: begin
                     cmd.capture = 1'b1;
                     scatter_in  = 1'b0;
                     state_in    = ST_EXEC;
                  end
                  OP_SCATTER: begin
                     cmd.capture = 1'b1;
                     scatter_in  = 1'b1;
                     state_in    = ST_EXEC;
                  end
                  default: begin
                     // unused code is dropped
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_EXEC: begin
            // a scatter waits until its result has somewhere to go
            if (!scatter_ff || status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            cmd.clear_step = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_SWEEP;
         scatter_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         scatter_ff <= scatter_in;
      end
   end

endmodule

[sv/rpcs_datapath.sv]
// datapath of the radix partition unit: bucket table, row counter, result register
// depends on rpcs_pkg; commanded by rpcs_ctrl
module rpcs_datapath
   import rpcs_pkg::*;
#(
   parameter int MAX_RADIX_BITS = 10,
   parameter int MAX_ROWS       = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic signed [31:0] key_value,
   input  logic [3:0]         radix_bit_count,
   input  logic               bypass_single_bucket,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output rsp_type            rsp_data
);

   localparam int BW    = MAX_RADIX_BITS;
   localparam int DEPTH = 1 << BW;
   localparam int CW    = $clog2(MAX_ROWS + 1);
   localparam int EW    = 2 * CW;

   // entry layout: count in the upper half, cursor in the lower half
   logic [EW-1:0] bucket_mem_ff [DEPTH];
   logic [EW-1:0] rdata_ff;

   logic [BW-1:0]          idx_ff, idx_in;
   logic [BUCKET_ID_W-1:0] bid_ff, bid_in;
   logic [BW-1:0]          sweep_ff, sweep_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [4:0]    bits_eff;
   logic [31:0]   mask32;
   logic [31:0]   bucket32;
   logic [BW-1:0] raddr;
   logic [BW-1:0] waddr;
   logic [EW-1:0] wdata;
   logic          we;
   logic [CW-1:0] cnt, cur, cnt_next, cur_next;
   logic [31:0]   slot32, size32;

   // bucket selection from the live configuration
   always_comb begin
      if ({1'b0, radix_bit_count} > 5'(MAX_RADIX_BITS)) begin
         bits_eff = 5'(MAX_RADIX_BITS);
      end else begin
         bits_eff = {1'b0, radix_bit_count};
      end
      mask32   = (32'd1 << bits_eff) - 32'd1;
      bucket32 = bypass_single_bucket ? 32'd0 : ($unsigned(key_value) & mask32);
   end

   assign idx_in = cmd.capture ? bucket32[BW-1:0] : idx_ff;
   assign bid_in = cmd.capture ? bucket32[BUCKET_ID_W-1:0] : bid_ff;
   assign raddr  = idx_in;

   // read-modify-write of the captured entry
   always_comb begin
      cnt = rdata_ff[EW-1:CW];
      cur = rdata_ff[CW-1:0];
      cnt_next = (cnt < CW'(MAX_ROWS)) ? cnt + CW'(1) : cnt;
      cur_next = (cur < CW'(MAX_ROWS)) ? cur + CW'(1) : cur;
      slot32 = 32'(cur);
      size32 = 32'(cnt);
   end

   always_comb begin
      we    = cmd.commit || cmd.clear_step;
      waddr = cmd.clear_step ? sweep_ff : idx_ff;
      if (cmd.clear_step) begin
         wdata = '0;
      end else if (cmd.scatter) begin
         wdata = {cnt, cur_next};
      end else begin
         wdata = {cnt_next, cur};
      end
   end

   assign sweep_in = cmd.clear_step ? sweep_ff + BW'(1) : sweep_ff;

   always_comb begin
      row_in = row_ff;
      if (cmd.clear_step) begin
         row_in = '0;
      end else if (cmd.commit && cmd.scatter) begin
         row_in = row_ff + ROW_W'(1);
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.commit && cmd.scatter) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.bucket_id      = bid_ff;
         rsp_data_in.slot_in_bucket = (slot32 > 32'hFFFF) ? 16'hFFFF : slot32[SLOT_W-1:0];
         rsp_data_in.row_number     = row_ff;
         rsp_data_in.bucket_size    = (size32 > 32'h1FFFF) ? 17'h1FFFF : size32[SIZE_W-1:0];
         rsp_data_in.overflow       = (cur >= cnt);
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         bucket_mem_ff[waddr] <= wdata;
      end
      rdata_ff <= bucket_mem_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sweep_ff     <= sweep_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      bid_ff      <= bid_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.sweep_last = &sweep_ff;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sv/radix_partition_count_scatter_unit.sv]
// top level of the radix partition count/scatter unit: config registers and assertions
// depends on rpcs_pkg, rpcs_ctrl, rpcs_datapath and the unit's macro header
//
// Two-pass radix partitioner on a 32-bit key. A count request raises the count of
// the key's bucket (its low radix_bit_count bits, or bucket 0 in bypass mode); a
// scatter request returns the bucket, the bucket's next slot, the row index, the
// bucket's counted size and an overflow flag. Count and scatter requests each read
// the bucket entry from the table into a register and then write it back, and
// req_stall holds off a new request until the write-back; a scatter also waits
// while a previous result is still stalled in the output register. A clear request,
// and reset itself, sweep the table one entry per cycle, all 2^MAX_RADIX_BITS entries
// (1024 by default), with req_stall high throughout. Configuration is to be written
// through the APB port while the unit is idle; the block itself does not enforce it.
`include "radix_partition_count_scatter_unit_macros.svh"

module radix_partition_count_scatter_unit
   import rpcs_pkg::*;
#(
   parameter int MAX_RADIX_BITS = 10,
   parameter int MAX_ROWS       = 65536
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   cmd_type    cmd;
   status_type status;

   logic [3:0] radix_ff, radix_in;
   logic       bypass_ff, bypass_in;
   logic       csr_write;
   logic       csr_index;

   // config registers, written at the access phase of an apb write
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[2];

   always_comb begin
      radix_in  = radix_ff;
      bypass_in = bypass_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_RADIX_BIT_COUNT: radix_in  = pwdata[3:0];
            REG_BYPASS:          bypass_in = pwdata[0];
            default:             radix_in  = radix_ff;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_index)
         REG_RADIX_BIT_COUNT: prdata = {28'd0, radix_ff};
         REG_BYPASS:          prdata = {31'd0, bypass_ff};
         default:             prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff  <= RADIX_BIT_COUNT_RESET;
         bypass_ff <= 1'b0;
      end else begin
         radix_ff  <= radix_in;
         bypass_ff <= bypass_in;
      end
   end

   // sequencing: idle / table update / clearing sweep
   rpcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // bucket table, row counter and result register
   rpcs_datapath #(
      .MAX_RADIX_BITS (MAX_RADIX_BITS),
      .MAX_ROWS       (MAX_ROWS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .key_value            (req_data.key_value),
      .radix_bit_count      (radix_ff),
      .bypass_single_bucket (bypass_ff),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_data             (rsp_data)
   );

   // a scatter result never overwrites one that is still stalled
   `RPCS_ASSERT_SAME(a_no_result_overwrite, cmd.commit && cmd.scatter, !rsp_valid || !rsp_stall)
   // a committed scatter shows up on the result channel next cycle
   `RPCS_ASSERT_NEXT(a_scatter_gives_result, cmd.commit && cmd.scatter, rsp_valid)
   // a captured request holds off the next one while its entry is updated
   `RPCS_ASSERT_NEXT(a_capture_then_stall, cmd.capture, req_stall)

endmodule
